### design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expands to a named concurrent assertion clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check while out of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### design/rrp_pkg.sv
`default_nettype none
package rrp_pkg;

  // Relocation kinds
  localparam logic [4:0] MODE_BRANCH     = 5'd0;
  localparam logic [4:0] MODE_JAL        = 5'd1;
  localparam logic [4:0] MODE_CALL       = 5'd2;
  localparam logic [4:0] MODE_HI20       = 5'd3;
  localparam logic [4:0] MODE_LO12_I     = 5'd4;
  localparam logic [4:0] MODE_LO12_S     = 5'd5;
  localparam logic [4:0] MODE_TPREL_LO_I = 5'd6;
  localparam logic [4:0] MODE_TPREL_LO_S = 5'd7;
  localparam logic [4:0] MODE_CBRANCH    = 5'd8;
  localparam logic [4:0] MODE_CJUMP      = 5'd9;
  localparam logic [4:0] MODE_ADD8       = 5'd10;
  localparam logic [4:0] MODE_ADD16      = 5'd11;
  localparam logic [4:0] MODE_ADD32      = 5'd12;
  localparam logic [4:0] MODE_ADD64      = 5'd13;
  localparam logic [4:0] MODE_SUB8       = 5'd14;
  localparam logic [4:0] MODE_SUB16      = 5'd15;
  localparam logic [4:0] MODE_SUB32      = 5'd16;
  localparam logic [4:0] MODE_SUB64      = 5'd17;
  localparam logic [4:0] MODE_SUB6       = 5'd18;
  localparam logic [4:0] MODE_SET6       = 5'd19;
  localparam logic [4:0] MODE_SET8       = 5'd20;
  localparam logic [4:0] MODE_SET16      = 5'd21;
  localparam logic [4:0] MODE_SET32      = 5'd22;
  localparam logic [4:0] MODE_PCREL_HI20 = 5'd23;
  localparam logic [4:0] MODE_WORD32     = 5'd24;
  localparam logic [4:0] MODE_TPREL_HI20 = 5'd25;

  // Relaxation sizes
  localparam logic [2:0] SHRINK_NONE = 3'd0;
  localparam logic [2:0] SHRINK_JAL  = 3'd4;
  localparam logic [2:0] SHRINK_CJ   = 3'd6;

  // Instruction field masks
  localparam logic [31:0] MASK_I   = 32'h000F_FFFF;
  localparam logic [31:0] MASK_SB  = 32'h01FF_F07F;
  localparam logic [31:0] MASK_UJ  = 32'h0000_0FFF;
  localparam logic [15:0] MASK_CB  = 16'hE383;
  localparam logic [15:0] MASK_CJ  = 16'hE003;
  localparam logic [31:0] MASK_RS1 = 32'hFFF0_7FFF;
  localparam logic [31:0] RS1_TP   = 32'h0002_0000;
  localparam logic [31:0] U_ROUND  = 32'h0000_0800;

  // Opcodes of relaxed calls
  localparam logic [6:0]  OPC_JAL = 7'b1101111;
  localparam logic [15:0] INS_CJ   = 16'hA001;
  localparam logic [15:0] INS_CJAL = 16'h2001;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;

  typedef struct packed {
    logic [4:0]         mode;
    logic [63:0]        old_bytes;
    logic signed [63:0] resolved;
    logic [2:0]         shrink_bytes;
    logic [4:0]         link_reg;
    logic               undef_weak;
  } req_t;

  typedef struct packed {
    logic [63:0] new_bytes;
    logic [3:0]  byte_count;
    logic        out_of_range;
    logic        bad_request;
  } rsp_t;

  function automatic logic [31:0] enc_i(input logic [31:0] v);
    return {v[11:0], 20'b0};
  endfunction

  function automatic logic [31:0] enc_s(input logic [31:0] v);
    return {v[11:5], 13'b0, v[4:0], 7'b0};
  endfunction

  function automatic logic [31:0] enc_b(input logic [31:0] v);
    return {v[12], v[10:5], 13'b0, v[4:1], v[11], 7'b0};
  endfunction

  function automatic logic [31:0] enc_j(input logic [31:0] v);
    return {v[20], v[10:1], v[11], v[19:12], 12'b0};
  endfunction

  function automatic logic [15:0] enc_cb(input logic [31:0] v);
    return {3'b0, v[8], v[4], v[3], 3'b0, v[7], v[6], v[2], v[1], v[5], 2'b0};
  endfunction

  function automatic logic [15:0] enc_cj(input logic [31:0] v);
    return {3'b0, v[11], v[4], v[9], v[8], v[10], v[6], v[7], v[3], v[2], v[1], v[5],
            2'b0};
  endfunction

  // Byte count of the 8/16/32/64 bit data kinds
  function automatic logic [3:0] width_bytes(input logic [1:0] idx);
    logic [3:0] n;
    unique case (idx)
      2'd0:    n = 4'd1;
      2'd1:    n = 4'd2;
      2'd2:    n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### design/riscv_reloc_patch_unit.sv
// Relocation patch unit: one request per cycle, result strobed on done_o
// once start is taken and the request has passed the input, arithmetic and insert stages.
// Throughput is one request per cycle; busy never rises and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) drops all in-flight requests and clears is_rv32.
// Configuration is taken in any cycle; write it only while the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"
module riscv_reloc_patch_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire rrp_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output rrp_pkg::rsp_t      result_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_data_i
);

  // The pipeline never stalls, so requests and config are always taken.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic is_rv32_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_rv32_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      is_rv32_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: capture the request.
  // ---------------------------------------------------------------------
  logic          a_valid_q;
  rrp_pkg::req_t a_req_q;

  // ---------------------------------------------------------------------
  // Stage B: wide arithmetic and range checks.
  // ---------------------------------------------------------------------
  logic [63:0] val_eff;
  logic [31:0] u_plain_d, u_eff_d;
  logic [63:0] sum_d, diff_d;
  logic        fit8_d, fit11_d, fit12_d, fit20_d, fit31_d, fit31_eff_d;

  logic        b_valid_q;
  logic [4:0]  b_mode_q;
  logic [63:0] b_old_q;
  logic [31:0] b_v_q;
  logic [11:0] b_ve12_q;
  logic [2:0]  b_shrink_q;
  logic [4:0]  b_rd_q;
  logic [63:0] b_sum_q, b_diff_q;
  logic [19:0] b_u_plain_q, b_u_eff_q;
  logic        b_fit8_q, b_fit11_q, b_fit12_q, b_fit20_q, b_fit31_q, b_fit31_eff_q;

  always_comb begin
    // The weak-zero value only matters for call pairs and pcrel hi20.
    val_eff   = a_req_q.undef_weak ? 64'd0 : a_req_q.resolved;
    u_plain_d = a_req_q.resolved[31:0] + rrp_pkg::U_ROUND;
    u_eff_d   = val_eff[31:0] + rrp_pkg::U_ROUND;
    sum_d     = a_req_q.old_bytes + a_req_q.resolved;
    diff_d    = a_req_q.old_bytes - a_req_q.resolved;
    // A value fits [-2^k, 2^k) when bits 63..k are all equal.
    fit8_d      = (&a_req_q.resolved[63:8])  || !(|a_req_q.resolved[63:8]);
    fit11_d     = (&a_req_q.resolved[63:11]) || !(|a_req_q.resolved[63:11]);
    fit12_d     = (&a_req_q.resolved[63:12]) || !(|a_req_q.resolved[63:12]);
    fit20_d     = (&a_req_q.resolved[63:20]) || !(|a_req_q.resolved[63:20]);
    fit31_d     = (&a_req_q.resolved[63:31]) || !(|a_req_q.resolved[63:31]);
    fit31_eff_d = (&val_eff[63:31]) || !(|val_eff[63:31]);
  end

  // ---------------------------------------------------------------------
  // Stage C: field insertion, byte merge and flags.
  // ---------------------------------------------------------------------
  logic [31:0] w;
  logic [31:0] ins32;
  logic [15:0] ins16;
  logic [63:0] patch;
  logic [3:0]  cnt;
  logic        oor, bad;
  logic [4:0]  widx;
  logic [63:0] merged;
  logic [7:0]  bmask;

  always_comb begin
    w      = b_old_q[31:0];
    patch  = b_old_q;
    cnt    = 4'd0;
    oor    = 1'b0;
    bad    = 1'b0;
    ins32  = 32'd0;
    ins16  = 16'd0;
    widx   = 5'd0;
    unique case (b_mode_q)
      rrp_pkg::MODE_BRANCH: begin
        oor   = !b_fit12_q;
        patch = {b_old_q[63:32], (w & rrp_pkg::MASK_SB) | rrp_pkg::enc_b(b_v_q)};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_JAL: begin
        oor   = !b_fit20_q;
        patch = {b_old_q[63:32], (w & rrp_pkg::MASK_UJ) | rrp_pkg::enc_j(b_v_q)};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_CALL: begin
        priority if (b_shrink_q == rrp_pkg::SHRINK_JAL) begin
          // Relax the pair to jal rd.
          ins32 = {20'd0, b_rd_q, rrp_pkg::OPC_JAL};
          oor   = !b_fit20_q;
          patch = {b_old_q[63:32], (ins32 & rrp_pkg::MASK_UJ) | rrp_pkg::enc_j(b_v_q)};
          cnt   = 4'd4;
        end else if (b_shrink_q == rrp_pkg::SHRINK_CJ &&
                     (b_rd_q == rrp_pkg::REG_ZERO ||
                      (b_rd_q == rrp_pkg::REG_RA && is_rv32_q))) begin
          // Relax to c.j or c.jal.
          ins16 = (b_rd_q == rrp_pkg::REG_ZERO) ? rrp_pkg::INS_CJ : rrp_pkg::INS_CJAL;
          oor   = !b_fit11_q;
          patch = {b_old_q[63:16], (ins16 & rrp_pkg::MASK_CJ) | rrp_pkg::enc_cj(b_v_q)};
          cnt   = 4'd2;
        end else if (b_shrink_q == rrp_pkg::SHRINK_NONE) begin
          // Keep the auipc/jalr pair.
          oor   = !b_fit31_eff_q;
          patch = {(b_old_q[63:32] & rrp_pkg::MASK_I) | {b_ve12_q, 20'd0},
                   (w & rrp_pkg::MASK_UJ) | {b_u_eff_q, 12'd0}};
          cnt   = 4'd8;
        end else begin
          bad = 1'b1;
        end
      end
      rrp_pkg::MODE_HI20: begin
        oor   = !b_fit31_q;
        patch = {b_old_q[63:32], (w & rrp_pkg::MASK_UJ) | {b_u_plain_q, 12'd0}};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_LO12_I, rrp_pkg::MODE_TPREL_LO_I: begin
        ins32 = (w & rrp_pkg::MASK_I) | rrp_pkg::enc_i(b_v_q);
        if (b_mode_q == rrp_pkg::MODE_TPREL_LO_I && b_fit11_q) begin
          ins32 = (ins32 & rrp_pkg::MASK_RS1) | rrp_pkg::RS1_TP;
        end
        patch = {b_old_q[63:32], ins32};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_LO12_S, rrp_pkg::MODE_TPREL_LO_S: begin
        ins32 = (w & rrp_pkg::MASK_SB) | rrp_pkg::enc_s(b_v_q);
        if (b_mode_q == rrp_pkg::MODE_TPREL_LO_S && b_fit11_q) begin
          ins32 = (ins32 & rrp_pkg::MASK_RS1) | rrp_pkg::RS1_TP;
        end
        patch = {b_old_q[63:32], ins32};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_CBRANCH: begin
        oor   = !b_fit8_q;
        patch = {b_old_q[63:16], (w[15:0] & rrp_pkg::MASK_CB) | rrp_pkg::enc_cb(b_v_q)};
        cnt   = 4'd2;
      end
      rrp_pkg::MODE_CJUMP: begin
        oor   = !b_fit11_q;
        patch = {b_old_q[63:16], (w[15:0] & rrp_pkg::MASK_CJ) | rrp_pkg::enc_cj(b_v_q)};
        cnt   = 4'd2;
      end
      rrp_pkg::MODE_ADD8, rrp_pkg::MODE_ADD16,
      rrp_pkg::MODE_ADD32, rrp_pkg::MODE_ADD64: begin
        widx  = b_mode_q - rrp_pkg::MODE_ADD8;
        cnt   = rrp_pkg::width_bytes(widx[1:0]);
        patch = b_sum_q;
      end
      rrp_pkg::MODE_SUB8, rrp_pkg::MODE_SUB16,
      rrp_pkg::MODE_SUB32, rrp_pkg::MODE_SUB64: begin
        widx  = b_mode_q - rrp_pkg::MODE_SUB8;
        cnt   = rrp_pkg::width_bytes(widx[1:0]);
        patch = b_diff_q;
      end
      rrp_pkg::MODE_SUB6: begin
        patch = {b_old_q[63:6], b_diff_q[5:0]};
        cnt   = 4'd1;
      end
      rrp_pkg::MODE_SET6: begin
        patch = {b_old_q[63:6], b_v_q[5:0]};
        cnt   = 4'd1;
      end
      rrp_pkg::MODE_SET8, rrp_pkg::MODE_SET16, rrp_pkg::MODE_SET32: begin
        widx  = b_mode_q - rrp_pkg::MODE_SET8;
        cnt   = rrp_pkg::width_bytes(widx[1:0]);
        patch = {b_old_q[63:32], b_v_q};
      end
      rrp_pkg::MODE_PCREL_HI20: begin
        patch = {b_old_q[63:32], (w & rrp_pkg::MASK_UJ) | {b_u_eff_q, 12'd0}};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_WORD32: begin
        patch = {b_old_q[63:32], b_v_q};
        cnt   = 4'd4;
      end
      rrp_pkg::MODE_TPREL_HI20: begin
        // Shrink 4 means the lui is gone: write nothing.
        if (b_shrink_q == rrp_pkg::SHRINK_NONE) begin
          patch = {b_old_q[63:32], (w & rrp_pkg::MASK_UJ) | {b_u_plain_q, 12'd0}};
          cnt   = 4'd4;
        end else if (b_shrink_q != rrp_pkg::SHRINK_JAL) begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // Keep the bytes above the count from the original site.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bmask[i] = (4'(i) < cnt);
    end
    for (int i = 0; i < 8; i++) begin
      merged[8*i +: 8] = bmask[i] ? patch[8*i +: 8] : b_old_q[8*i +: 8];
    end
  end

  logic          c_valid_q;
  rrp_pkg::rsp_t c_rsp_q;

  // ---------------------------------------------------------------------
  // Valid bits: advance one stage per cycle, drop on reset.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start && !busy;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Payload registers load freely; valid bits qualify them.
  always_ff @(posedge clk_i) begin
    a_req_q       <= req_i;

    b_mode_q      <= a_req_q.mode;
    b_old_q       <= a_req_q.old_bytes;
    b_v_q         <= a_req_q.resolved[31:0];
    b_ve12_q      <= val_eff[11:0];
    b_shrink_q    <= a_req_q.shrink_bytes;
    b_rd_q        <= a_req_q.link_reg;
    b_sum_q       <= sum_d;
    b_diff_q      <= diff_d;
    b_u_plain_q   <= u_plain_d[31:12];
    b_u_eff_q     <= u_eff_d[31:12];
    b_fit8_q      <= fit8_d;
    b_fit11_q     <= fit11_d;
    b_fit12_q     <= fit12_d;
    b_fit20_q     <= fit20_d;
    b_fit31_q     <= fit31_d;
    b_fit31_eff_q <= fit31_eff_d;

    c_rsp_q.new_bytes    <= merged;
    c_rsp_q.byte_count   <= cnt;
    c_rsp_q.out_of_range <= oor;
    c_rsp_q.bad_request  <= bad;
  end

  assign done_o   = c_valid_q;
  assign result_o = c_rsp_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_RST(a_latency_hit, (start && !busy) |-> ##3 done_o, "request lost in pipeline")
  `ASSERT_RST(a_latency_miss, !(start && !busy) |-> ##3 !done_o, "result without request")
  `ASSERT_RST(a_bad_no_write, (done_o && result_o.bad_request) |-> (result_o.byte_count == 4'd0),
              "rejected request writes bytes")
  `ASSERT_RST(a_oor_kind, (done_o && result_o.out_of_range) |->
              (!result_o.bad_request && (result_o.byte_count == 4'd2 ||
               result_o.byte_count == 4'd4 || result_o.byte_count == 4'd8)),
              "range flag on unchecked kind")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !done_o, "strobe during reset")

endmodule
`default_nettype wire
